FILE: design/sbus_frame_receiver_macros.svh
// Assertion macros used by the checker file of the frame receiver.
`ifndef SBUS_FRAME_RECEIVER_MACROS_SVH
`define SBUS_FRAME_RECEIVER_MACROS_SVH

// Condition implies consequence in the same cycle.
`define SFR_ASSERT_NOW(label, clk, rst, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error(msg);

// Condition implies consequence in the next cycle.
`define SFR_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/sfr_pkg.sv
package sfr_pkg;

  // Frame layout.
  localparam int FRAME_BYTES  = 25;
  localparam int NUM_CHANNELS = 16;
  localparam int FLAGS_POS    = 23;
  localparam int STORE_DEPTH  = FRAME_BYTES - 1;
  localparam int CHAN_W       = 11;
  localparam int IDX_W        = 4;
  localparam int COUNT_W      = $clog2(FRAME_BYTES);
  localparam int ERR_W        = 16;

  // Data bytes 1 to 22 hold the channels, byte 23 holds the flags.
  localparam int PAYLOAD_W = 8 * (FLAGS_POS - 1);
  localparam int SHIFT_W   = 8 * FLAGS_POS;

  localparam logic [7:0] START_CODE = 8'h0F;
  localparam logic [7:0] END_CODE   = 8'h00;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    PS_SYNC  = 2'd0,
    PS_START = 2'd1,
    PS_DATA  = 2'd2
  } parse_state_t;

  // One finished frame handed from the parser to the emitter.
  typedef struct packed {
    logic                 good;
    logic [7:0]           flags;
    logic [ERR_W-1:0]     err_count;
    logic [PAYLOAD_W-1:0] payload;
  } sfr_job_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } sfr_qstat_t;

  // Saturating increment of the bad frame counter.
  function automatic logic [ERR_W-1:0] sat_inc(input logic [ERR_W-1:0] v);
    sat_inc = (v == {ERR_W{1'b1}}) ? v : v + ERR_W'(1);
  endfunction

endpackage

FILE: design/sfr_queue.sv
module sfr_queue
  import sfr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  sfr_job_t   push_job,
  input  logic       pop,
  output sfr_job_t   head_job,
  output sfr_qstat_t stat
);

  sfr_job_t            slots [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   fill;

  assign stat.full  = (fill == QCNT_W'(QDEPTH));
  assign stat.empty = (fill == '0);
  assign head_job   = slots[rd_ptr];

  // Pointer and fill bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + QCNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - QCNT_W'(1);
      end
    end
  end

  // Slot storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

endmodule

FILE: design/sfr_front.sv
module sfr_front
  import sfr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_ready,
  input  logic [7:0] rx_byte,
  input  sfr_qstat_t qstat,
  output logic       push,
  output sfr_job_t   push_job
);

  parse_state_t        state;
  parse_state_t        state_next;
  logic [7:0]          last_rx;
  logic [COUNT_W-1:0]  byte_count;
  logic [COUNT_W-1:0]  byte_count_next;
  logic [SHIFT_W-1:0]  frame_data;
  logic [ERR_W-1:0]    bad_count;
  logic                accept;
  logic                frame_end;
  logic                end_ok;
  logic                store_en;

  assign byte_ready = !qstat.full;
  assign accept     = byte_valid && byte_ready;
  assign end_ok     = (rx_byte == END_CODE);

  // Next state and byte position.
  always_comb begin
    state_next      = state;
    byte_count_next = byte_count;
    case (state)
      PS_START: begin
        if (rx_byte == START_CODE && last_rx == END_CODE) begin
          state_next      = PS_DATA;
          byte_count_next = COUNT_W'(1);
        end else begin
          state_next = PS_SYNC;
        end
      end
      PS_DATA: begin
        if (byte_count == COUNT_W'(FRAME_BYTES - 1)) begin
          state_next      = end_ok ? PS_START : PS_SYNC;
          byte_count_next = '0;
        end else begin
          byte_count_next = byte_count + COUNT_W'(1);
        end
      end
      default: begin
        state_next = (end_ok && last_rx == END_CODE) ? PS_START : PS_SYNC;
      end
    endcase
  end

  // Outputs of the parser: capture strobe and frame hand-off.
  always_comb begin
    store_en  = 1'b0;
    frame_end = 1'b0;
    case (state)
      PS_DATA: begin
        store_en  = (byte_count < COUNT_W'(STORE_DEPTH));
        frame_end = (byte_count == COUNT_W'(FRAME_BYTES - 1));
      end
      default: begin
        store_en  = 1'b0;
        frame_end = 1'b0;
      end
    endcase
  end

  assign push              = accept && frame_end;
  assign push_job.good     = end_ok;
  assign push_job.flags    = frame_data[SHIFT_W-1 -: 8];
  assign push_job.err_count = end_ok ? bad_count : sat_inc(bad_count);
  assign push_job.payload  = frame_data[PAYLOAD_W-1:0];

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= PS_START;
      last_rx    <= START_CODE;
      byte_count <= '0;
      bad_count  <= '0;
    end else if (accept) begin
      state      <= state_next;
      last_rx    <= rx_byte;
      byte_count <= byte_count_next;
      if (frame_end && !end_ok) begin
        bad_count <= sat_inc(bad_count);
      end
    end
  end

  // Data bytes shift in from the top so byte 1 ends up in the low bits.
  always_ff @(posedge clk) begin
    if (accept && store_en) begin
      frame_data <= {rx_byte, frame_data[SHIFT_W-1:8]};
    end
  end

endmodule

FILE: design/sfr_back.sv
module sfr_back
  import sfr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  sfr_job_t          head_job,
  input  sfr_qstat_t        qstat,
  output logic              pop,
  output logic              res_valid,
  input  logic              res_ready,
  output logic [IDX_W-1:0]  channel_index,
  output logic [CHAN_W-1:0] channel_value,
  output logic [7:0]        frame_flags,
  output logic              frame_good,
  output logic [ERR_W-1:0]  error_count,
  output logic              last
);

  logic                 active;
  logic [IDX_W-1:0]     ch;
  logic [PAYLOAD_W-1:0] bits;
  logic                 good;
  logic [7:0]           flags;
  logic [ERR_W-1:0]     err_count;
  logic                 res_accept;

  assign res_valid  = active;
  assign res_accept = active && res_ready;
  assign last       = !good || (ch == IDX_W'(NUM_CHANNELS - 1));
  assign pop        = !qstat.empty && (!active || (res_accept && last));

  // Result fields come straight from the held job; error results keep only the error count, the other fields zeroed.
  assign channel_index = good ? ch : '0;
  assign channel_value = good ? bits[CHAN_W-1:0] : '0;
  assign frame_flags   = good ? flags : '0;
  assign frame_good    = good;
  assign error_count   = err_count;

  // Run control.
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (pop) begin
      active <= 1'b1;
    end else if (res_accept && last) begin
      active <= 1'b0;
    end
  end

  // Job payload: load on pop, step one channel per accepted result.
  always_ff @(posedge clk) begin
    if (pop) begin
      ch        <= '0;
      bits      <= head_job.payload;
      good      <= head_job.good;
      flags     <= head_job.flags;
      err_count <= head_job.err_count;
    end else if (res_accept) begin
      ch   <= ch + IDX_W'(1);
      bits <= {{CHAN_W{1'b0}}, bits[PAYLOAD_W-1:CHAN_W]};
    end
  end

endmodule

FILE: design/sbus_frame_receiver.sv
// Channel  Dir  Payload
// s_*      in   tdata[7:0] rx_byte
// m_*      out  tdata channel fields and error count, tuser frame_good, tlast last
//
// One byte is taken per cycle while s_tready is high. An accepted end byte puts
// its frame into a two-frame queue between the parser and the result emitter;
// the emitter pops it when free, and a good frame then yields 16 results on
// consecutive cycles while m_tready stays high, a bad frame one error result.
// s_tready drops only while the queue is full. Reset is synchronous and clears
// all control state; the parser then waits for a start byte after two 0x00s.
module sbus_frame_receiver
  import sfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [3:0] channel_index, [14:4] channel_value,
                                 // [22:15] frame_flags, [38:23] error_count, [39] zero
  output logic        m_tuser,   // [0] frame_good
  output logic        m_tlast
);

  sfr_qstat_t          qstat;
  sfr_job_t            push_job;
  sfr_job_t            head_job;
  logic                push;
  logic                pop;
  logic [IDX_W-1:0]    channel_index;
  logic [CHAN_W-1:0]   channel_value;
  logic [7:0]          frame_flags;
  logic [ERR_W-1:0]    error_count;

  sfr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (s_tvalid),
    .byte_ready (s_tready),
    .rx_byte    (s_tdata),
    .qstat      (qstat),
    .push       (push),
    .push_job   (push_job)
  );

  sfr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .stat     (qstat)
  );

  sfr_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head_job      (head_job),
    .qstat         (qstat),
    .pop           (pop),
    .res_valid     (m_tvalid),
    .res_ready     (m_tready),
    .channel_index (channel_index),
    .channel_value (channel_value),
    .frame_flags   (frame_flags),
    .frame_good    (m_tuser),
    .error_count   (error_count),
    .last          (m_tlast)
  );

  // Pack the result fields, lowest field first.
  assign m_tdata = {1'b0, error_count, frame_flags, channel_value, channel_index};

endmodule

FILE: design/sfr_checker.sv
`include "sbus_frame_receiver_macros.svh"

module sfr_checker
  import sfr_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic        m_tuser,
  input logic        m_tlast
);

  logic m_stall;
  logic m_accept;

  assign m_stall  = m_tvalid && !m_tready;
  assign m_accept = m_tvalid && m_tready;

  // A stalled result keeps its payload.
  `SFR_ASSERT_NEXT(a_hold, clk, rst, m_stall,
    m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast),
    "result changed while stalled")

  // An error result is a single, final result with channel and flag fields zeroed.
  `SFR_ASSERT_NOW(a_err_zero, clk, rst, m_tvalid && !m_tuser,
    m_tlast && m_tdata[22:0] == 23'd0,
    "error result not zeroed or not final")

  // Within a good frame the channels follow each other without a gap.
  `SFR_ASSERT_NEXT(a_next_ch, clk, rst, m_accept && !m_tlast,
    m_tvalid && m_tuser && m_tdata[3:0] == $past(m_tdata[3:0]) + 4'd1,
    "channel sequence broken")

  // The final good result carries the highest channel index.
  `SFR_ASSERT_NOW(a_last_ch, clk, rst, m_tvalid && m_tuser && m_tlast,
    m_tdata[3:0] == IDX_W'(NUM_CHANNELS - 1),
    "good frame ended on the wrong channel")

endmodule

bind sbus_frame_receiver sfr_checker u_sfr_checker (.*);
